[sv/pdv_cell_energy_density_update_macros.svh]
// Assertion macros for the file that carries concurrent checks.
`ifndef PDV_CELL_ENERGY_DENSITY_UPDATE_MACROS_SVH
`define PDV_CELL_ENERGY_DENSITY_UPDATE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PDVU_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, not gated by reset.
`define PDVU_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pdvu_pkg.sv]
// Shared widths, constants and the queue entry type of the pdV cell update.
package pdvu_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned AREA_W     = 32;
  localparam int unsigned PROD_W     = 50;
  localparam int unsigned PF_W       = 52;
  localparam int unsigned PFMAG_W    = 51;
  localparam int unsigned DT_W       = 32;
  localparam int unsigned PLO_W      = 64;
  localparam int unsigned PHI_W      = PFMAG_W - 32 + DT_W;
  localparam int unsigned FS_W       = 84;
  localparam int unsigned FLUX_SHIFT = 38;
  localparam int unsigned FMAG_W     = FS_W - FLUX_SHIFT;
  localparam int unsigned FMAG_LO_W  = 23;
  localparam int unsigned PQ_W       = 33;
  localparam int unsigned MP_W       = PQ_W + FMAG_LO_W;
  localparam int unsigned EP_W       = MP_W + FMAG_LO_W;
  localparam int unsigned DEN_W      = 47;
  localparam int unsigned RHOV_W     = 62;
  localparam int unsigned NR_W       = 49;
  localparam int unsigned D2R_W      = DEN_W;
  localparam int unsigned NE_W       = 96;
  localparam int unsigned D2E_W      = RHOV_W + 1;
  localparam int unsigned RQ_W       = 31;
  localparam int unsigned EQ_W       = 41;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned Q_DEPTH    = 4;

  localparam logic [31:0]       SAT32 = 32'h7FFF_FFFF;
  localparam logic [EQ_W-1:0]   ECAP  = {1'b1, {(EQ_W-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICT_MODE = 2'd1;

  // Work handed from the front end to the divider back end.
  typedef struct packed {
    logic                    fault;
    logic                    add_m;
    logic [30:0]             rho;
    logic signed [31:0]      e0;
    logic [NR_W-1:0]         n_r;
    logic [D2R_W-1:0]        d2_r;
    logic [NE_W-1:0]         n_e;
    logic [D2E_W-1:0]        d2_e;
  } pdvu_job_t;

endpackage

[sv/pdvu_front.sv]
// Front end: accepts cells, forms face fluxes, total flux and divider operands.
module pdvu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          time_step,
  input  logic                 predict_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          x_areas,
  input  logic [63:0]          y_areas,
  input  logic [63:0]          xv_old,
  input  logic [63:0]          xv_new,
  input  logic [63:0]          yv_old,
  input  logic [63:0]          yv_new,
  input  logic [30:0]          vol,
  input  logic [30:0]          rho,
  input  logic signed [31:0]   e0,
  input  logic signed [31:0]   pres,
  input  logic signed [31:0]   visc,
  output logic                 push,
  output pdvu_pkg::pdvu_job_t  job,
  input  logic                 full
);
  import pdvu_pkg::*;

  function automatic logic signed [SUM_W-1:0] face_sum(
    input logic [63:0] o, input logic [63:0] n, input int a, input int b, input logic pm);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'($signed(o[VEL_W*a +: VEL_W])) + SUM_W'($signed(o[VEL_W*b +: VEL_W]));
    if (!pm) begin
      s = s + SUM_W'($signed(n[VEL_W*a +: VEL_W])) + SUM_W'($signed(n[VEL_W*b +: VEL_W]));
    end
    return s;
  endfunction

  logic adv;

  // stage 1: face velocity sums
  logic                       v1_r;
  logic signed [SUM_W-1:0]    sl1_r, sr1_r, sb1_r, st1_r;
  logic [AREA_W-1:0]          al1_r, ar1_r, ab1_r, at1_r;
  logic [30:0]                vol1_r, rho1_r;
  logic signed [31:0]         e01_r;
  logic signed [PQ_W-1:0]     pq1_r;
  // stage 2: area products
  logic                       v2_r;
  logic signed [PROD_W-1:0]   pl2_r, pr2_r, pb2_r, pt2_r;
  logic [PQ_W-1:0]            pqm2_r;
  logic                       pqn2_r;
  logic [30:0]                vol2_r, rho2_r;
  logic signed [31:0]         e02_r;
  // stage 3: net flux sum magnitude
  logic                       v3_r;
  logic [PFMAG_W-1:0]         pfm3_r;
  logic                       pfn3_r;
  logic [PQ_W-1:0]            pqm3_r;
  logic                       pqn3_r;
  logic [30:0]                vol3_r, rho3_r;
  logic signed [31:0]         e03_r;
  // stage 4: times dt, split
  logic                       v4_r;
  logic [PLO_W-1:0]           plo4_r;
  logic [PHI_W-1:0]           phi4_r;
  logic                       pfn4_r;
  logic [PQ_W-1:0]            pqm4_r;
  logic                       pqn4_r;
  logic [30:0]                vol4_r, rho4_r;
  logic signed [31:0]         e04_r;
  // stage 5: rounded flux, rho*V
  logic                       v5_r;
  logic [FMAG_W-1:0]          fm5_r;
  logic [RHOV_W-1:0]          rv5_r;
  logic                       pfn5_r;
  logic [PQ_W-1:0]            pqm5_r;
  logic                       pqn5_r;
  logic [30:0]                vol5_r, rho5_r;
  logic signed [31:0]         e05_r;
  // stage 6: denominator, fault, work products
  logic                       v6_r;
  logic signed [DEN_W-1:0]    den6_r;
  logic                       flt6_r, addm6_r;
  logic [MP_W-1:0]            mlo6_r, mhi6_r;
  logic [RHOV_W-1:0]          rv6_r;
  logic [30:0]                vol6_r, rho6_r;
  logic signed [31:0]         e06_r;
  // stage 7: combined work product, ratio operands
  logic                       v7_r;
  logic [EP_W-1:0]            ep7_r;
  logic [RHOV_W-1:0]          rv7_r;
  logic [NR_W-1:0]            nr7_r;
  logic [D2R_W-1:0]           d2r7_r;
  logic                       flt7_r, addm7_r;
  logic [30:0]                rho7_r;
  logic signed [31:0]         e07_r;
  // stage 8: energy numerator, queue entry
  logic                       v8_r;
  pdvu_job_t                  job8_r;

  logic signed [PF_W-1:0]     pf_nxt;
  logic [FS_W-1:0]            fs_nxt;
  logic                       fneg_nxt;
  logic signed [DEN_W-1:0]    den_nxt;

  assign adv      = !v8_r || !full;
  assign in_ready = adv;
  assign push     = v8_r && !full;
  assign job      = job8_r;

  always_comb begin
    pf_nxt   = PF_W'(pr2_r) - PF_W'(pl2_r) + PF_W'(pt2_r) - PF_W'(pb2_r);
    fs_nxt   = FS_W'({phi4_r, 32'b0}) + FS_W'(plo4_r) + (FS_W'(1) << (FLUX_SHIFT - 1));
    fneg_nxt = pfn5_r && (fm5_r != '0);
    den_nxt  = fneg_nxt ? DEN_W'(vol5_r) - DEN_W'(fm5_r) : DEN_W'(vol5_r) + DEN_W'(fm5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl1_r  <= face_sum(xv_old, xv_new, 0, 2, predict_mode);
      sr1_r  <= face_sum(xv_old, xv_new, 1, 3, predict_mode);
      sb1_r  <= face_sum(yv_old, yv_new, 0, 1, predict_mode);
      st1_r  <= face_sum(yv_old, yv_new, 2, 3, predict_mode);
      al1_r  <= x_areas[31:0];  ar1_r <= x_areas[63:32];
      ab1_r  <= y_areas[31:0];  at1_r <= y_areas[63:32];
      vol1_r <= vol; rho1_r <= rho; e01_r <= e0;
      pq1_r  <= PQ_W'(pres) + PQ_W'(visc);

      pl2_r  <= PROD_W'($signed({1'b0, al1_r})) * PROD_W'(sl1_r);
      pr2_r  <= PROD_W'($signed({1'b0, ar1_r})) * PROD_W'(sr1_r);
      pb2_r  <= PROD_W'($signed({1'b0, ab1_r})) * PROD_W'(sb1_r);
      pt2_r  <= PROD_W'($signed({1'b0, at1_r})) * PROD_W'(st1_r);
      pqm2_r <= pq1_r[PQ_W-1] ? PQ_W'(-pq1_r) : PQ_W'(pq1_r);
      pqn2_r <= pq1_r[PQ_W-1];
      vol2_r <= vol1_r; rho2_r <= rho1_r; e02_r <= e01_r;

      pfm3_r <= pf_nxt[PF_W-1] ? PFMAG_W'(-pf_nxt) : PFMAG_W'(pf_nxt);
      pfn3_r <= pf_nxt[PF_W-1];
      pqm3_r <= pqm2_r; pqn3_r <= pqn2_r;
      vol3_r <= vol2_r; rho3_r <= rho2_r; e03_r <= e02_r;

      plo4_r <= PLO_W'(pfm3_r[31:0]) * PLO_W'(time_step);
      phi4_r <= PHI_W'(pfm3_r[PFMAG_W-1:32]) * PHI_W'(time_step);
      pfn4_r <= pfn3_r; pqm4_r <= pqm3_r; pqn4_r <= pqn3_r;
      vol4_r <= vol3_r; rho4_r <= rho3_r; e04_r <= e03_r;

      fm5_r  <= fs_nxt[FLUX_SHIFT +: FMAG_W];
      rv5_r  <= RHOV_W'(rho4_r) * RHOV_W'(vol4_r);
      pfn5_r <= pfn4_r; pqm5_r <= pqm4_r; pqn5_r <= pqn4_r;
      vol5_r <= vol4_r; rho5_r <= rho4_r; e05_r <= e04_r;

      den6_r  <= den_nxt;
      flt6_r  <= (vol5_r == '0) || (rho5_r == '0) || den_nxt[DEN_W-1] || (den_nxt == '0);
      addm6_r <= pqn5_r ^ fneg_nxt;
      mlo6_r  <= MP_W'(pqm5_r) * MP_W'(fm5_r[FMAG_LO_W-1:0]);
      mhi6_r  <= MP_W'(pqm5_r) * MP_W'(fm5_r[FMAG_W-1:FMAG_LO_W]);
      rv6_r   <= rv5_r; vol6_r <= vol5_r; rho6_r <= rho5_r; e06_r <= e05_r;

      ep7_r   <= EP_W'(mlo6_r) + (EP_W'(mhi6_r) << FMAG_LO_W);
      nr7_r   <= NR_W'({vol6_r, 17'b0}) + NR_W'(den6_r[DEN_W-2:0]);
      d2r7_r  <= {den6_r[DEN_W-2:0], 1'b0};
      rv7_r   <= rv6_r; flt7_r <= flt6_r; addm7_r <= addm6_r;
      rho7_r  <= rho6_r; e07_r <= e06_r;

      job8_r.fault <= flt7_r;
      job8_r.add_m <= addm7_r;
      job8_r.rho   <= rho7_r;
      job8_r.e0    <= e07_r;
      job8_r.n_r   <= nr7_r;
      job8_r.d2_r  <= d2r7_r;
      job8_r.n_e   <= {ep7_r, 17'b0} + NE_W'(rv7_r);
      job8_r.d2_e  <= {rv7_r, 1'b0};
    end
  end

endmodule

[sv/pdvu_queue.sv]
// Short FIFO between the front end and the divider back end.
module pdvu_queue #(
  parameter int unsigned DEPTH = pdvu_pkg::Q_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pdvu_pkg::pdvu_job_t  din,
  output logic                 full,
  input  logic                 pop,
  output pdvu_pkg::pdvu_job_t  dout,
  output logic                 empty
);
  import pdvu_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pdvu_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[sv/pdvu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, optional delay pad.
module pdvu_div #(
  parameter int unsigned Q_BITS = pdvu_pkg::EQ_W,
  parameter int unsigned D_W    = pdvu_pkg::D2E_W,
  parameter int unsigned LAT    = pdvu_pkg::EQ_W
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [D_W-1:0]    rem_i,
  input  logic [Q_BITS-1:0] low_i,
  input  logic [D_W-1:0]    d2_i,
  output logic [Q_BITS-1:0] q_o
);

  logic [D_W-1:0]    rem_r [Q_BITS];
  logic [Q_BITS-1:0] low_r [Q_BITS];
  logic [Q_BITS-1:0] q_r   [Q_BITS];
  logic [D_W-1:0]    d2_r  [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_st
    logic [D_W-1:0]    rem_in, d2_in;
    logic [Q_BITS-1:0] low_in, q_in;
    logic [D_W:0]      trial;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign q_in   = '0;
      assign d2_in  = d2_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign d2_in  = d2_r[k-1];
    end

    assign trial = {rem_in, low_in[Q_BITS-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (trial >= {1'b0, d2_in}) begin
          rem_r[k] <= D_W'(trial - {1'b0, d2_in});
          q_r[k]   <= {q_in[Q_BITS-2:0], 1'b1};
        end else begin
          rem_r[k] <= D_W'(trial);
          q_r[k]   <= {q_in[Q_BITS-2:0], 1'b0};
        end
        low_r[k] <= {low_in[Q_BITS-2:0], 1'b0};
        d2_r[k]  <= d2_in;
      end
    end
  end

  if (LAT > Q_BITS) begin : g_pad
    logic [Q_BITS-1:0] pad_r [LAT-Q_BITS];
    always_ff @(posedge clk) begin
      if (adv) begin
        pad_r[0] <= q_r[Q_BITS-1];
        for (int i = 1; i < LAT - Q_BITS; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end
    assign q_o = pad_r[LAT-Q_BITS-1];
  end else begin : g_nopad
    assign q_o = q_r[Q_BITS-1];
  end

endmodule

[sv/pdvu_back.sv]
// Back end: range checks, ratio and work dividers, final density and energy.
module pdvu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdvu_pkg::pdvu_job_t  job,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   volume_ratio,
  output logic signed [31:0]   density_new,
  output logic signed [31:0]   energy_new,
  output logic                 divide_fault
);
  import pdvu_pkg::*;

  localparam int unsigned LAT = EQ_W;

  typedef struct packed {
    logic               fault;
    logic               add_m;
    logic               sat_r;
    logic               sat_e;
    logic [30:0]        rho;
    logic signed [31:0] e0;
  } side_t;

  logic                adv;
  logic                pv_r;
  side_t               psb_r;
  logic [D2R_W-1:0]    prem_r_r, pd2r_r;
  logic [RQ_W-1:0]     plow_r_r;
  logic [D2E_W-1:0]    prem_e_r, pd2e_r;
  logic [EQ_W-1:0]     plow_e_r;
  logic                dv_r [LAT];
  side_t               dsb_r [LAT];
  logic [RQ_W-1:0]     qr;
  logic [EQ_W-1:0]     qe;

  logic                x1v_r, x1flt_r;
  logic [RHOV_W-1:0]   x1dp_r;
  logic [30:0]         x1ratio_r;
  logic signed [31:0]  x1e_r;
  logic                ov_r, oflt_r;
  logic signed [31:0]  orat_r, oden_r, oen_r;

  side_t               last;
  logic [RQ_W-1:0]     ratio_nxt;
  logic [EQ_W-1:0]     m_nxt;
  logic signed [42:0]  e1_nxt;
  logic signed [31:0]  esat_nxt;
  logic [RHOV_W:0]     dr_nxt;
  logic [31:0]         dens_nxt;

  assign adv          = !ov_r || out_ready;
  assign pop          = adv && !empty;
  assign out_valid    = ov_r;
  assign volume_ratio = orat_r;
  assign density_new  = oden_r;
  assign energy_new   = oen_r;
  assign divide_fault = oflt_r;

  pdvu_div #(.Q_BITS(RQ_W), .D_W(D2R_W), .LAT(LAT)) u_div_ratio (
    .clk(clk), .adv(adv), .rem_i(prem_r_r), .low_i(plow_r_r), .d2_i(pd2r_r), .q_o(qr)
  );

  pdvu_div #(.Q_BITS(EQ_W), .D_W(D2E_W), .LAT(LAT)) u_div_work (
    .clk(clk), .adv(adv), .rem_i(prem_e_r), .low_i(plow_e_r), .d2_i(pd2e_r), .q_o(qe)
  );

  always_comb begin
    last      = dsb_r[LAT-1];
    ratio_nxt = last.sat_r ? SAT32[RQ_W-1:0] : qr;
    m_nxt     = (last.sat_e || (qe > ECAP)) ? ECAP : qe;
    e1_nxt    = last.add_m ? 43'(last.e0) + 43'(m_nxt) : 43'(last.e0) - 43'(m_nxt);
    if (e1_nxt > 43'sd2147483647) begin
      esat_nxt = $signed(SAT32);
    end else if (e1_nxt < -43'sd2147483648) begin
      esat_nxt = $signed(~SAT32);
    end else begin
      esat_nxt = e1_nxt[31:0];
    end
    dr_nxt   = (RHOV_W + 1)'(x1dp_r) + (RHOV_W + 1)'(16'h8000);
    dens_nxt = (dr_nxt[RHOV_W:16] > (RHOV_W - 15)'(SAT32)) ? SAT32 : dr_nxt[47:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      x1v_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      pv_r    <= !empty;
      dv_r[0] <= pv_r;
      for (int i = 1; i < LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      x1v_r <= dv_r[LAT-1];
      ov_r  <= x1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      psb_r.fault <= job.fault;
      psb_r.add_m <= job.add_m;
      psb_r.rho   <= job.rho;
      psb_r.e0    <= job.e0;
      psb_r.sat_r <= (78'(job.n_r) >= {job.d2_r, 31'b0});
      psb_r.sat_e <= (104'(job.n_e) >= {job.d2_e, 41'b0});
      prem_r_r    <= D2R_W'(job.n_r[NR_W-1:RQ_W]);
      plow_r_r    <= job.n_r[RQ_W-1:0];
      pd2r_r      <= job.d2_r;
      prem_e_r    <= D2E_W'(job.n_e[NE_W-1:EQ_W]);
      plow_e_r    <= job.n_e[EQ_W-1:0];
      pd2e_r      <= job.d2_e;

      dsb_r[0] <= psb_r;
      for (int i = 1; i < LAT; i++) begin
        dsb_r[i] <= dsb_r[i-1];
      end

      x1flt_r   <= last.fault;
      x1ratio_r <= ratio_nxt;
      x1dp_r    <= RHOV_W'(last.rho) * RHOV_W'(ratio_nxt);
      x1e_r     <= esat_nxt;

      oflt_r <= x1flt_r;
      orat_r <= x1flt_r ? $signed(SAT32) : $signed({1'b0, x1ratio_r});
      oden_r <= x1flt_r ? $signed(SAT32) : $signed(dens_nxt);
      oen_r  <= x1flt_r ? $signed(SAT32) : x1e_r;
    end
  end

endmodule

[sv/pdv_cell_energy_density_update.sv]
// Top level of the Lagrangian pdV density and energy update for one cell per transaction.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | areas, corner velocities, V, rho, e, p, q
//  out_    | output    | out_valid/out_ready | volume ratio, density, energy, fault flag
//  cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wdata (time step, mode)
//
// Throughput: one transaction per cycle in each direction while out_ready is not held low.
// Stages: 8 front stages, the queue, 1 range-check stage, 41 divider stages
//   (one quotient bit each, set by the 41-bit work quotient) and 2 final stages.
// Reset (rst_n low, synchronous) empties all stages and the queue; time step 0,
//   predictor mode. No clearing pass.
// A stall on out_ready holds the back end; the front keeps taking transactions
//   until the queue fills, and in_ready depends only on registered state.
`include "pdv_cell_energy_density_update_macros.svh"

module pdv_cell_energy_density_update #(
  parameter int unsigned QUEUE_DEPTH = pdvu_pkg::Q_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pdvu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_x_face_areas,
  input  logic [63:0]                     in_y_face_areas,
  input  logic [63:0]                     in_xvel_old_corners,
  input  logic [63:0]                     in_xvel_new_corners,
  input  logic [63:0]                     in_yvel_old_corners,
  input  logic [63:0]                     in_yvel_new_corners,
  input  logic [30:0]                     in_cell_volume,
  input  logic [30:0]                     in_density_old,
  input  logic signed [31:0]              in_energy_old,
  input  logic signed [31:0]              in_cell_pressure,
  input  logic signed [31:0]              in_cell_viscosity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_volume_ratio,
  output logic signed [31:0]              out_density_new,
  output logic signed [31:0]              out_energy_new,
  output logic                            out_divide_fault
);
  import pdvu_pkg::*;

  logic [31:0] time_step_r;
  logic        predict_mode_r;

  logic        q_push, q_full, q_pop, q_empty;
  pdvu_job_t   q_din, q_dout;

  // config decode; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r    <= '0;
      predict_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIME_STEP:    time_step_r    <= cfg_wdata;
        REG_PREDICT_MODE: predict_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // flux and operand formation
  pdvu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .time_step(time_step_r), .predict_mode(predict_mode_r),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_areas(in_x_face_areas), .y_areas(in_y_face_areas),
    .xv_old(in_xvel_old_corners), .xv_new(in_xvel_new_corners),
    .yv_old(in_yvel_old_corners), .yv_new(in_yvel_new_corners),
    .vol(in_cell_volume), .rho(in_density_old), .e0(in_energy_old),
    .pres(in_cell_pressure), .visc(in_cell_viscosity),
    .push(q_push), .job(q_din), .full(q_full)
  );

  // decouples front stalls from output back-pressure
  pdvu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  // dividers and final rounding
  pdvu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job(q_dout), .empty(q_empty), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .volume_ratio(out_volume_ratio), .density_new(out_density_new),
    .energy_new(out_energy_new), .divide_fault(out_divide_fault)
  );

  // a faulted cell carries saturated values in every field
  `PDVU_CHECK(a_fault_saturates, out_valid && out_divide_fault,
    (out_volume_ratio == $signed(SAT32)) && (out_density_new == $signed(SAT32)) &&
    (out_energy_new == $signed(SAT32)), "fault result not saturated")
  // a good cell never yields a negative ratio or density
  `PDVU_CHECK(a_ratio_nonneg, out_valid && !out_divide_fault,
    !out_volume_ratio[31] && !out_density_new[31], "negative ratio or density")
  // reset drains the output stage
  `PDVU_CHECK_NEXT(a_reset_drains, !rst_n, !out_valid, "output valid after reset")

endmodule

[test/pdv_cell_energy_density_update_test.sv]
// Testbench for the pdV cell density and energy update: random cells checked against a predictor.
`timescale 1ns / 100ps

module pdv_cell_energy_density_update_test;
  import pdvu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;

  // One cell as presented on the input channel.
  typedef struct {
    logic [63:0]        xa, ya, xo, xn, yo, yn;
    logic [30:0]        vol, rho;
    logic signed [31:0] e0, p, q;
  } cell_t;

  // One expected or observed transaction on the output channel.
  typedef struct {
    logic signed [31:0] ratio, dens, energy;
    logic               fault;
  } update_t;

  // Scoreboard: predicts each accepted cell and checks the outputs in order.
  class pdv_scoreboard;
    logic [31:0] dt;
    bit          predict;
    update_t     pending[$];
    int          mismatches;

    function new();
      dt = '0;
      predict = 1'b1;
      mismatches = 0;
    endfunction

    function longint corner(logic [63:0] v, int c);
      logic signed [15:0] s;
      s = v[16*c +: 16];
      return longint'(s);
    endfunction

    function longint face(logic [63:0] o, logic [63:0] n, int a, int b);
      longint s;
      s = corner(o, a) + corner(o, b);
      if (!predict) s += corner(n, a) + corner(n, b);
      return s;
    endfunction

    // round(num/den) with ties up, capped
    function logic [127:0] div_cap(logic [127:0] num, logic [127:0] den, logic [127:0] cap);
      logic [127:0] r;
      r = (2 * num + den) / (2 * den);
      return (r > cap) ? cap : r;
    endfunction

    function void note_cell(cell_t c);
      longint pf, flux, den, pq, e1;
      logic [127:0] pmag, fmag, ratio, dens, m;
      update_t u;
      pf = longint'(c.xa[63:32]) * face(c.xo, c.xn, 1, 3)
         - longint'(c.xa[31:0])  * face(c.xo, c.xn, 0, 2)
         + longint'(c.ya[63:32]) * face(c.yo, c.yn, 2, 3)
         - longint'(c.ya[31:0])  * face(c.yo, c.yn, 0, 1);
      pmag = (pf < 0) ? 128'(-pf) : 128'(pf);
      fmag = (pmag * 128'(dt) + (128'd1 << 37)) >> 38;
      flux = (pf < 0) ? -longint'(fmag) : longint'(fmag);
      den = longint'(c.vol) + flux;
      if (c.vol == 0 || c.rho == 0 || den <= 0) begin
        u = '{SAT32, SAT32, SAT32, 1'b1};
      end else begin
        ratio = div_cap(128'(c.vol) << 16, 128'(den), 128'(SAT32));
        dens = (128'(c.rho) * ratio + 128'h8000) >> 16;
        if (dens > 128'(SAT32)) dens = 128'(SAT32);
        pq = longint'(c.p) + longint'(c.q);
        m = div_cap((((pq < 0) ? 128'(-pq) : 128'(pq)) * fmag) << 16,
                    128'(c.rho) * 128'(c.vol), 128'd1 << 40);
        e1 = ((pq < 0) != (flux < 0)) ? longint'(c.e0) + longint'(m)
                                      : longint'(c.e0) - longint'(m);
        if (e1 > 64'sd2147483647) e1 = 64'sd2147483647;
        if (e1 < -64'sd2147483648) e1 = -64'sd2147483648;
        u = '{ratio[31:0], dens[31:0], e1[31:0], 1'b0};
      end
      pending.push_back(u);
    endfunction

    function void check_update(update_t got);
      update_t exp_u;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction: %p", got);
        return;
      end
      exp_u = pending.pop_front();
      if (got.ratio !== exp_u.ratio || got.dens !== exp_u.dens ||
          got.energy !== exp_u.energy || got.fault !== exp_u.fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected ratio %h dens %h energy %h fault %b, got %h %h %h %b",
                   exp_u.ratio, exp_u.dens, exp_u.energy, exp_u.fault,
                   got.ratio, got.dens, got.energy, got.fault);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] in_x_face_areas = '0, in_y_face_areas = '0;
  logic [63:0] in_xvel_old_corners = '0, in_xvel_new_corners = '0;
  logic [63:0] in_yvel_old_corners = '0, in_yvel_new_corners = '0;
  logic [30:0] in_cell_volume = '0, in_density_old = '0;
  logic signed [31:0] in_energy_old = '0, in_cell_pressure = '0, in_cell_viscosity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_volume_ratio, out_density_new, out_energy_new;
  logic out_divide_fault;

  pdv_cell_energy_density_update i_dut (.*);

  pdv_scoreboard sb = new();
  bit     quiet = 1'b0;   // set for the final stretch: no idling on either side
  longint cycles = 0;

  always #4 clk = ~clk;

  // Monitor: both channels sampled at the rising edge.
  always @(posedge clk) begin
    cell_t c;
    if (rst_n && in_valid && in_ready) begin
      c = '{in_x_face_areas, in_y_face_areas, in_xvel_old_corners, in_xvel_new_corners,
            in_yvel_old_corners, in_yvel_new_corners, in_cell_volume, in_density_old,
            in_energy_old, in_cell_pressure, in_cell_viscosity};
      sb.note_cell(c);
    end
    if (rst_n && out_valid && out_ready)
      sb.check_update('{out_volume_ratio, out_density_new, out_energy_new, out_divide_fault});
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver backpressure: random stall bursts, none once quiet.
  initial begin
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_TIME_STEP) sb.dt = val;
    else if (idx == REG_PREDICT_MODE) sb.predict = val[0];
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_cell(cell_t c);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    {in_x_face_areas, in_y_face_areas} = {c.xa, c.ya};
    {in_xvel_old_corners, in_xvel_new_corners} = {c.xo, c.xn};
    {in_yvel_old_corners, in_yvel_new_corners} = {c.yo, c.yn};
    {in_cell_volume, in_density_old} = {c.vol, c.rho};
    {in_energy_old, in_cell_pressure, in_cell_viscosity} = {c.e0, c.p, c.q};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Block is idle once nothing is pending and the pipe has had time to empty.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    // small areas keep the flux near the volume so most cells take the normal path
    if ($urandom_range(0, 2) == 0) begin
      c.xa = rnd64();
      c.ya = rnd64();
    end else begin
      c.xa = {12'd0, 20'($urandom()), 12'd0, 20'($urandom())};
      c.ya = {12'd0, 20'($urandom()), 12'd0, 20'($urandom())};
    end
    {c.xo, c.xn, c.yo, c.yn} = {rnd64(), rnd64(), rnd64(), rnd64()};
    c.vol = ($urandom_range(0, 1) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 1 << 20));
    c.rho = ($urandom_range(0, 30) == 0) ? 31'd0 : 31'($urandom());
    c.e0 = $urandom();
    c.p = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($signed(16'($urandom())));
    c.q = $urandom();
    if ($urandom_range(0, 40) == 0) c.vol = '0;
    return c;
  endfunction

  task automatic directed_cells();
    cell_t c;
    c = '{'0, '0, '0, '0, '0, '0, 31'd65536, 31'd65536, 32'sd0, 32'sd0, 32'sd0};
    send_cell(c);                                  // no motion: ratio one
    c.xa = '1; c.ya = '1; c.xo = '1; c.xn = '1; c.yo = '1; c.yn = '1;
    c.vol = '1; c.rho = '1; c.e0 = '1; c.p = '1; c.q = '1;
    send_cell(c);                                  // all ones
    c = '{{32'hFFFF_FFFF, 32'd0}, '0, {4{16'h7FFF}}, {4{16'h7FFF}}, '0, '0,
          31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_cell(c);                                  // strongest expansion
    c.xo = {4{16'h8000}}; c.xn = {4{16'h8000}};
    c.e0 = 32'h8000_0000; c.p = 32'h8000_0000; c.q = 32'h8000_0000;
    send_cell(c);                                  // compression, volume may collapse
    c.vol = 31'd1;
    send_cell(c);                                  // tiny volume: negative divisor
    c.vol = '0;
    send_cell(c);                                  // zero volume
    c.vol = 31'd65536; c.rho = '0;
    send_cell(c);                                  // zero density
    c = '{{32'd0, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'd0}, {4{16'h0001}}, {4{16'h8000}},
          {4{16'hFFFF}}, {4{16'h7FFF}}, 31'd3, 31'd1, 32'sd5, 32'sd1, -32'sd1};
    send_cell(c);                                  // p+q cancels; new velocities differ
  endtask

  initial begin
    logic [31:0] dts [6];
    int n;
    dts = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_1000, 32'd0, 32'h0000_0001, 32'h0010_0000};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);    // ignored
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TIME_STEP, (ph == 2) ? $urandom() : dts[ph]);
      write_reg(REG_PREDICT_MODE, 32'(ph % 2 == 0));
      if (ph < 2) directed_cells();
      if (ph == 5) quiet = 1'b1;
      n = 275;
      for (int i = 0; i < n; i++) send_cell(random_cell());
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
